// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked on every edge outside reset
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== rtl/core/rdsrt_pkg.sv =====
// ----------------------------------------------------------------------------
// rdsrt_pkg
// shared types, constants and character filters for the rds text assembler
// ----------------------------------------------------------------------------
`default_nettype none

package rdsrt_pkg;

  // group type codes in block b[15:12]
  localparam logic [3:0] GTYPE_NAME = 4'd0;
  localparam logic [3:0] GTYPE_TEXT = 4'd2;
  localparam logic       VERSION_A  = 1'b0;

  // printable range limits
  localparam logic [7:0] CHAR_LO      = 8'd32;
  localparam logic [7:0] NAME_CHAR_HI = 8'd126;

  localparam int unsigned NAME_CHARS = 8;
  localparam int unsigned SEG_COUNT  = 16;
  localparam int unsigned SEG_AW     = 4;
  localparam int unsigned SEG_W      = 32;

  // write request into the segment memory
  typedef struct packed {
    logic              en;
    logic [SEG_AW-1:0] addr;
    logic [SEG_W-1:0]  data;
  } txt_wr_t;

  // station name characters: 32..126
  function automatic logic name_char_ok(input logic [7:0] ch);
    return (ch >= CHAR_LO) && (ch <= NAME_CHAR_HI);
  endfunction

  // radio text characters: 32..127, a set top bit is rejected
  function automatic logic text_char_ok(input logic [7:0] ch);
    return !ch[7] && (ch >= CHAR_LO);
  endfunction

  // merge the four bytes of c and d into a stored segment
  function automatic logic [31:0] text_merge(input logic [31:0] old_word,
                                             input logic [15:0] blk_c,
                                             input logic [15:0] blk_d);
    logic [31:0] src;
    logic [31:0] res;
    src = {blk_c, blk_d};
    res = old_word;
    for (int k = 0; k < 4; k++) begin
      if (text_char_ok(src[31-8*k -: 8])) begin
        res[31-8*k -: 8] = src[31-8*k -: 8];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rdsrt_seg_mem.sv =====
// ----------------------------------------------------------------------------
// rdsrt_seg_mem
// radio text segment memory: one write, one registered read, per-entry valid
// bits for the zero reset state and same-edge write forwarding
// ----------------------------------------------------------------------------
`default_nettype none

module rdsrt_seg_mem
  import rdsrt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rd_en,
  input  wire logic [SEG_AW-1:0] rd_addr,
  input  wire txt_wr_t           wr,
  output logic      [SEG_W-1:0]  rd_data
);

  logic [SEG_W-1:0] mem [SEG_COUNT];
  logic [SEG_COUNT-1:0] vld;
  logic [SEG_W-1:0] q_mem;
  logic [SEG_W-1:0] q_fwd_data;
  logic             q_fwd;
  logic             q_vld;

  // storage array, no reset
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      q_mem <= mem[rd_addr];
    end
  end

  // entry valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  // read side qualifiers, a write on the read edge wins
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_fwd      <= wr.en && (wr.addr == rd_addr);
      q_fwd_data <= wr.data;
      q_vld      <= vld[rd_addr];
    end
  end

  always_comb begin
    if (q_fwd) begin
      rd_data = q_fwd_data;
    end else if (q_vld) begin
      rd_data = q_mem;
    end else begin
      rd_data = '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rds_ps_radiotext_assembler_core.sv =====
// ----------------------------------------------------------------------------
// rds_ps_radiotext_assembler_core
// path: the memory read and the stage 1 register are loaded at the accepting
// edge, the update is loaded into the output register when stage 1 advances
// throughput: one group per cycle while the output is not stalled, read-modify-write
// of the segment memory with same-address forwarding between back-to-back groups
// reset: name and radio text read as all zero, no clearing pass needed
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rds_ps_radiotext_assembler_core
  import rdsrt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        group_ready,
  input  wire logic [15:0] block_b,
  input  wire logic [15:0] block_c,
  input  wire logic [15:0] block_d,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             updated_now,
  output logic [63:0]      station_name,
  output logic [3:0]       text_segment_index,
  output logic [31:0]      text_segment
);

  // stage 1 word, memory read in flight
  logic        s1_valid;
  logic        s1_ready;
  logic [15:0] s1_b;
  logic [15:0] s1_c;
  logic [15:0] s1_d;

  logic        s1_adv;
  logic        in_take;
  logic [31:0] seg_old;
  logic [31:0] seg_new;
  logic        is_name;
  logic        is_text;
  txt_wr_t     wr;

  logic [7:0]  name_store [NAME_CHARS];
  logic [7:0]  name_next  [NAME_CHARS];
  logic [63:0] name_flat;
  logic [2:0]  idx_hi;
  logic [2:0]  idx_lo;

  // handshake
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  rdsrt_seg_mem u_seg_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_take),
    .rd_addr (block_b[3:0]),
    .wr      (wr),
    .rd_data (seg_old)
  );

  // group decode
  assign is_name = s1_ready && (s1_b[15:12] == GTYPE_NAME);
  assign is_text = s1_ready && (s1_b[15:12] == GTYPE_TEXT) && (s1_b[11] == VERSION_A);

  // segment update and write back
  always_comb begin
    seg_new = is_text ? text_merge(seg_old, s1_c, s1_d) : seg_old;
    wr.en   = s1_adv && is_text;
    wr.addr = s1_b[3:0];
    wr.data = seg_new;
  end

  // station name update
  assign idx_hi = {s1_b[1:0], 1'b0};
  assign idx_lo = {s1_b[1:0], 1'b1};

  always_comb begin
    for (int i = 0; i < NAME_CHARS; i++) begin
      name_next[i] = name_store[i];
    end
    if (is_name) begin
      if (name_char_ok(s1_d[15:8])) begin
        name_next[idx_hi] = s1_d[15:8];
      end
      if (name_char_ok(s1_d[7:0])) begin
        name_next[idx_lo] = s1_d[7:0];
      end
    end
    for (int i = 0; i < NAME_CHARS; i++) begin
      name_flat[63-8*i -: 8] = name_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NAME_CHARS; i++) begin
        name_store[i] <= '0;
      end
    end else if (s1_adv) begin
      for (int i = 0; i < NAME_CHARS; i++) begin
        name_store[i] <= name_next[i];
      end
    end
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_ready <= group_ready;
      s1_b     <= block_b;
      s1_c     <= block_c;
      s1_d     <= block_d;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      updated_now        <= is_name || is_text;
      station_name       <= name_flat;
      text_segment_index <= s1_b[3:0];
      text_segment       <= seg_new;
    end
  end

  // checks
  `ASSERT_CLK(a_stall_only_when_full, in_stall |-> (s1_valid && out_valid && out_stall))
  `ASSERT_CLK(a_write_on_advance, wr.en |-> (s1_adv && s1_ready))
  `ASSERT_CLK(a_adv_fills_output, s1_adv |=> out_valid)
  `ASSERT_ALWAYS(a_reset_empties, rst |=> (!s1_valid && !out_valid))

endmodule

`default_nettype wire
